// ===== hdl/drrl_pkg.sv =====
// Shared types, register indexes and action codes of the DVFS request rate limiter.
package drrl_pkg;

	// Fixed field widths
	localparam int NOW_W    = 48;
	localparam int FREQ_W   = 32;
	localparam int US_W     = 24;
	localparam int CNT_W    = 8;
	localparam int ACT_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Default width of the stored time values
	localparam int TIME_BITS_DEF = 48;

	// Largest error count (saturation point)
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	// Largest backoff exponent
	localparam logic [CNT_W-1:0] SHIFT_MAX = 8'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FW_PATH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRICT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAFE_FREQ    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIMIT  = 3'd6;

	// Register reset values
	localparam logic [US_W-1:0]  MIN_INTERVAL_RST = 24'd100000;
	localparam logic [US_W-1:0]  BACKOFF_BASE_RST = 24'd500000;
	localparam logic [US_W-1:0]  BACKOFF_MAX_RST  = 24'd4000000;
	localparam logic [CNT_W-1:0] BOOST_LIMIT_RST  = 8'd3;

	// Operation codes
	localparam logic OP_VOTE   = 1'b0;
	localparam logic OP_RESUME = 1'b1;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_DIRECT      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_BACKOFF     = 4'd1;
	localparam logic [ACT_W-1:0] ACT_DUPLICATE   = 4'd2;
	localparam logic [ACT_W-1:0] ACT_RATELIMITED = 4'd3;
	localparam logic [ACT_W-1:0] ACT_SET_OK      = 4'd4;
	localparam logic [ACT_W-1:0] ACT_SET_FAIL    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_BOOST_OK    = 4'd6;
	localparam logic [ACT_W-1:0] ACT_BOOST_FAIL  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_RESUMED     = 4'd8;

	// Vote word
	typedef struct packed {
		logic              op;
		logic [NOW_W-1:0]  now_us;
		logic [FREQ_W-1:0] tgt_hz;
		logic [FREQ_W-1:0] meas_hz;
		logic              confirm_match;
		logic              set_ok;
		logic              boost_ok;
		logic [FREQ_W-1:0] actual_after_freq;
	} vote_t;

	// Result word
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic              issue_set;
		logic              issue_boost;
		logic [FREQ_W-1:0] reported_freq;
		logic [CNT_W-1:0]  error_count;
		logic [US_W-1:0]   penalty_us;
	} result_t;

	// Configuration registers
	typedef struct packed {
		logic              firmware_path_enabled;
		logic              strict_confirm;
		logic [FREQ_W-1:0] fallback_hz;
		logic [US_W-1:0]   min_interval_us;
		logic [US_W-1:0]   backoff_base_us;
		logic [US_W-1:0]   backoff_max_us;
		logic [CNT_W-1:0]  boost_error_limit;
	} cfg_t;

	// State update enables
	typedef struct packed {
		logic freq_we;
		logic time_we;
		logic cnt_we;
		logic hold_we;
	} state_we_t;

endpackage

// ===== hdl/drrl_vote_if.sv =====
// Vote channel: valid/ready handshake carrying one vote word.
interface drrl_vote_if;
	logic            valid;
	logic            ready;
	drrl_pkg::vote_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/drrl_result_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
interface drrl_result_if;
	logic              valid;
	logic              ready;
	drrl_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/drrl_decide.sv =====
// Decision logic: classifies one vote and computes the result word and next limiter state.
module drrl_decide #(
	parameter int TIME_BITS = drrl_pkg::TIME_BITS_DEF
) (
	input  drrl_pkg::cfg_t                 cfg,
	input  drrl_pkg::vote_t                vote,
	input  logic [drrl_pkg::FREQ_W-1:0]    last_freq,
	input  logic [TIME_BITS-1:0]           last_time,
	input  logic [drrl_pkg::CNT_W-1:0]     err_cnt,
	input  logic [TIME_BITS-1:0]           hold_until,
	output drrl_pkg::result_t              result,
	output drrl_pkg::state_we_t            state_we,
	output logic [drrl_pkg::FREQ_W-1:0]    last_freq_nxt,
	output logic [TIME_BITS-1:0]           last_time_nxt,
	output logic [drrl_pkg::CNT_W-1:0]     err_cnt_nxt,
	output logic [TIME_BITS-1:0]           hold_until_nxt
);

	localparam logic [TIME_BITS-1:0] TIME_MASK = {TIME_BITS{1'b1}};

	logic [TIME_BITS-1:0]          now_t;
	logic [TIME_BITS-1:0]          min_ivl_t;
	logic [TIME_BITS-1:0]          elapsed;
	logic                          in_backoff;
	logic                          is_dup;
	logic                          rate_hit;
	logic [drrl_pkg::CNT_W-1:0]    cnt_inc;
	logic [drrl_pkg::CNT_W-1:0]    shift_raw;
	logic [1:0]                    shift;
	logic [drrl_pkg::US_W+2:0]     backoff_wide;
	logic [drrl_pkg::US_W-1:0]     backoff;
	logic [TIME_BITS:0]            hold_sum;
	logic [TIME_BITS-1:0]          hold_fail;
	logic                          boost_due;

	// Time compares
	assign now_t      = TIME_BITS'(vote.now_us);
	assign min_ivl_t  = TIME_BITS'(cfg.min_interval_us);
	assign elapsed    = now_t - last_time;
	assign in_backoff = now_t < hold_until;
	assign rate_hit   = (now_t < last_time) || (elapsed < min_ivl_t);

	// Duplicate check, strict mode also needs the clock and firmware to agree
	assign is_dup = (vote.tgt_hz == last_freq) &&
		(!cfg.strict_confirm ||
		 ((vote.meas_hz == vote.tgt_hz) && vote.confirm_match));

	// Failure path: saturating count, exponential backoff, saturating hold end
	assign cnt_inc      = (err_cnt != drrl_pkg::CNT_MAX) ? err_cnt + 1'b1 : err_cnt;
	assign shift_raw    = cnt_inc - 1'b1;
	assign shift        = (shift_raw > drrl_pkg::SHIFT_MAX) ? 2'd3 : shift_raw[1:0];
	assign backoff_wide = {3'b000, cfg.backoff_base_us} << shift;
	assign backoff      = (backoff_wide > {3'b000, cfg.backoff_max_us}) ?
		cfg.backoff_max_us : backoff_wide[drrl_pkg::US_W-1:0];
	assign hold_sum     = {1'b0, now_t} + (TIME_BITS+1)'(backoff);
	assign hold_fail    = hold_sum[TIME_BITS] ? TIME_MASK : hold_sum[TIME_BITS-1:0];
	assign boost_due    = (cnt_inc >= cfg.boost_error_limit) &&
		(cfg.fallback_hz != '0) && (last_freq != cfg.fallback_hz);

	// Outcome selection
	always_comb begin
		result.action        = drrl_pkg::ACT_DIRECT;
		result.issue_set     = 1'b0;
		result.issue_boost   = 1'b0;
		result.reported_freq = vote.tgt_hz;
		result.error_count   = err_cnt;
		result.penalty_us    = '0;
		state_we             = '0;
		last_freq_nxt        = vote.tgt_hz;
		last_time_nxt        = now_t;
		err_cnt_nxt          = '0;
		hold_until_nxt       = '0;

		if (vote.op == drrl_pkg::OP_RESUME) begin
			result.action        = drrl_pkg::ACT_RESUMED;
			result.reported_freq = '0;
			result.error_count   = '0;
			state_we             = '1;
			last_freq_nxt        = '0;
			last_time_nxt        = '0;
		end else if (!cfg.firmware_path_enabled) begin
			result.issue_set = 1'b1;
		end else if (in_backoff) begin
			result.action        = drrl_pkg::ACT_BACKOFF;
			result.reported_freq = vote.meas_hz;
		end else if (is_dup) begin
			result.action = drrl_pkg::ACT_DUPLICATE;
		end else if (rate_hit) begin
			result.action        = drrl_pkg::ACT_RATELIMITED;
			result.reported_freq = vote.meas_hz;
		end else if (vote.set_ok) begin
			result.action      = drrl_pkg::ACT_SET_OK;
			result.issue_set   = 1'b1;
			result.error_count = '0;
			state_we           = '1;
		end else begin
			result.issue_set     = 1'b1;
			result.error_count   = cnt_inc;
			result.penalty_us    = backoff;
			result.reported_freq = vote.actual_after_freq;
			state_we.cnt_we      = 1'b1;
			state_we.hold_we     = 1'b1;
			err_cnt_nxt          = cnt_inc;
			hold_until_nxt       = hold_fail;
			last_freq_nxt        = cfg.fallback_hz;
			if (boost_due) begin
				result.issue_boost = 1'b1;
				if (vote.boost_ok) begin
					result.action        = drrl_pkg::ACT_BOOST_OK;
					result.reported_freq = cfg.fallback_hz;
					state_we.freq_we     = 1'b1;
					state_we.time_we     = 1'b1;
				end else begin
					result.action = drrl_pkg::ACT_BOOST_FAIL;
				end
			end else begin
				result.action = drrl_pkg::ACT_SET_FAIL;
			end
		end
	end

endmodule

// ===== hdl/dvfs_request_rate_limiter_core.sv =====
// Top level of the DVFS request rate limiter: registers, handshake and state.
// The block takes one frequency vote (or resume) per clock cycle while results are taken and
// returns one result word per vote, in order. A vote is captured in an input register,
// classified by combinational decision logic against the limiter state, and its result
// lands in an output register at the edge where the captured vote advances; the limiter
// state is updated at that same edge, so the next vote sees it with no bubble. A stalled
// output holds one result and one captured vote before ready drops. Configuration registers
// are written through the plain write port; they should be written only while no vote is in
// flight, which the block does not enforce. Writes to unknown indexes are ignored. TIME_BITS
// sets the width of the stored times; the time of a vote is taken modulo 2^TIME_BITS.
module dvfs_request_rate_limiter_core #(
	parameter int TIME_BITS = drrl_pkg::TIME_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [drrl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [drrl_pkg::CFG_DATA_W-1:0]   cfg_data,
	drrl_vote_if.sink                         vote_in,
	drrl_result_if.source                     result_out
);

	drrl_pkg::cfg_t              cfg_q;
	logic                        valid_s1;
	drrl_pkg::vote_t             vote_s1;
	logic                        out_valid_q;
	drrl_pkg::result_t           out_word_q;
	logic [drrl_pkg::FREQ_W-1:0] last_freq_q;
	logic [TIME_BITS-1:0]        last_time_q;
	logic [drrl_pkg::CNT_W-1:0]  err_cnt_q;
	logic [TIME_BITS-1:0]        hold_until_q;

	drrl_pkg::result_t           result;
	drrl_pkg::state_we_t         state_we;
	logic [drrl_pkg::FREQ_W-1:0] last_freq_nxt;
	logic [TIME_BITS-1:0]        last_time_nxt;
	logic [drrl_pkg::CNT_W-1:0]  err_cnt_nxt;
	logic [TIME_BITS-1:0]        hold_until_nxt;
	logic                        advance;
	logic                        take_in;

	// Handshake: the captured vote moves on whenever the output register is free or drains
	assign advance          = valid_s1 && (!out_valid_q || result_out.ready);
	assign vote_in.ready    = !valid_s1 || advance;
	assign take_in          = vote_in.valid && vote_in.ready;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_word_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.firmware_path_enabled <= 1'b1;
			cfg_q.strict_confirm        <= 1'b0;
			cfg_q.fallback_hz           <= '0;
			cfg_q.min_interval_us       <= drrl_pkg::MIN_INTERVAL_RST;
			cfg_q.backoff_base_us       <= drrl_pkg::BACKOFF_BASE_RST;
			cfg_q.backoff_max_us        <= drrl_pkg::BACKOFF_MAX_RST;
			cfg_q.boost_error_limit     <= drrl_pkg::BOOST_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				drrl_pkg::REG_FW_PATH: begin
					cfg_q.firmware_path_enabled <= cfg_data[0];
				end
				drrl_pkg::REG_STRICT: begin
					cfg_q.strict_confirm <= cfg_data[0];
				end
				drrl_pkg::REG_SAFE_FREQ: begin
					cfg_q.fallback_hz <= cfg_data[drrl_pkg::FREQ_W-1:0];
				end
				drrl_pkg::REG_MIN_INTERVAL: begin
					cfg_q.min_interval_us <= cfg_data[drrl_pkg::US_W-1:0];
				end
				drrl_pkg::REG_BACKOFF_BASE: begin
					cfg_q.backoff_base_us <= cfg_data[drrl_pkg::US_W-1:0];
				end
				drrl_pkg::REG_BACKOFF_MAX: begin
					cfg_q.backoff_max_us <= cfg_data[drrl_pkg::US_W-1:0];
				end
				drrl_pkg::REG_BOOST_LIMIT: begin
					cfg_q.boost_error_limit <= cfg_data[drrl_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Valid flags of the input and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the input and output registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			vote_s1 <= vote_in.data;
		end
		if (advance) begin
			out_word_q <= result;
		end
	end

	// Limiter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_freq_q  <= '0;
			last_time_q  <= '0;
			err_cnt_q    <= '0;
			hold_until_q <= '0;
		end else if (advance) begin
			if (state_we.freq_we) begin
				last_freq_q <= last_freq_nxt;
			end
			if (state_we.time_we) begin
				last_time_q <= last_time_nxt;
			end
			if (state_we.cnt_we) begin
				err_cnt_q <= err_cnt_nxt;
			end
			if (state_we.hold_we) begin
				hold_until_q <= hold_until_nxt;
			end
		end
	end

	// Decision logic
	drrl_decide #(
		.TIME_BITS (TIME_BITS)
	) u_decide (
		.cfg            (cfg_q),
		.vote           (vote_s1),
		.last_freq      (last_freq_q),
		.last_time      (last_time_q),
		.err_cnt        (err_cnt_q),
		.hold_until     (hold_until_q),
		.result         (result),
		.state_we       (state_we),
		.last_freq_nxt  (last_freq_nxt),
		.last_time_nxt  (last_time_nxt),
		.err_cnt_nxt    (err_cnt_nxt),
		.hold_until_nxt (hold_until_nxt)
	);

endmodule
